// ----- hw/rtl/sbfe_pkg.sv -----
// Shared types and constants of the SBUS frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package sbfe_pkg;

   localparam int unsigned PulseWidth     = 16;
   localparam int unsigned RawWidth       = 11;
   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned BytesPerEntry  = 4;
   localparam int unsigned EntryCntWidth  = 3;
   localparam int unsigned ChanWidth      = 4;
   localparam int unsigned PendWidth      = 7;
   localparam int unsigned PendCntWidth   = 3;
   localparam int unsigned CsrIndexWidth  = 8;
   localparam int unsigned CsrDataWidth   = 16;
   localparam int unsigned QueueDepth     = 2;
   localparam int unsigned ScaledWidth    = 29;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CsrPulseMin  = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPulseMax  = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CsrFrameLost = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CsrFailsafe  = 8'd3;

   localparam logic [PulseWidth-1:0] PulseMinReset = 16'd988;
   localparam logic [PulseWidth-1:0] PulseMaxReset = 16'd2012;

   localparam logic [ByteWidth-1:0] HeaderByte    = 8'h0F;
   localparam logic [ByteWidth-1:0] FooterByte    = 8'h00;
   localparam logic [ByteWidth-1:0] FlagFrameLost = 8'h04;
   localparam logic [ByteWidth-1:0] FlagFailsafe  = 8'h08;

   localparam logic [ChanWidth-1:0] FirstChannel = 4'd0;
   localparam logic [ChanWidth-1:0] LastChannel  = 4'd15;

   // scaling: ((u - 988) * 1639 + 512) / 1024 + 172, clamped to 172..1811
   localparam logic signed [ScaledWidth-1:0] ScaleCenter = 29'sd988;
   localparam logic signed [ScaledWidth-1:0] ScaleMul    = 29'sd1639;
   localparam logic signed [ScaledWidth-1:0] RoundBias   = 29'sd512;
   localparam logic signed [ScaledWidth-1:0] TruncBias   = 29'sd1023;
   localparam int unsigned                   ScaleShift  = 10;
   localparam logic signed [19:0]            RawMin      = 20'sd172;
   localparam logic signed [19:0]            RawMax      = 20'sd1811;

   // pending count at which one channel completes two data bytes
   localparam logic [PendCntWidth-1:0] TwoByteCount = 3'd5;

   typedef struct packed {
      logic [BytesPerEntry-1:0][ByteWidth-1:0] bytes;
      logic [EntryCntWidth-1:0]                count;       // 1..4 bytes
      logic                                    has_footer;  // last byte ends the frame
   } entry_type;

endpackage
`default_nettype wire

// ----- hw/rtl/sbfe_front.sv -----
// Front end: registers, pulse clamp and scale pipeline, bit packer.
`timescale 1ns / 1ps
`default_nettype none
module sbfe_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sbfe_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [sbfe_pkg::CsrDataWidth-1:0]    csr_data,
   input  wire logic                                 req_push,
   input  wire logic [sbfe_pkg::PulseWidth-1:0]      req_pulse_us,
   output logic                                      req_full,
   output logic                                      push_valid,
   output sbfe_pkg::entry_type                       push_entry,
   input  wire logic                                 q_full
);

   logic [sbfe_pkg::PulseWidth-1:0] pulse_min_ff;
   logic [sbfe_pkg::PulseWidth-1:0] pulse_max_ff;
   logic                            frame_lost_ff;
   logic                            failsafe_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff  <= sbfe_pkg::PulseMinReset;
         pulse_max_ff  <= sbfe_pkg::PulseMaxReset;
         frame_lost_ff <= 1'b0;
         failsafe_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            sbfe_pkg::CsrPulseMin:  pulse_min_ff  <= csr_data;
            sbfe_pkg::CsrPulseMax:  pulse_max_ff  <= csr_data;
            sbfe_pkg::CsrFrameLost: frame_lost_ff <= csr_data[0];
            sbfe_pkg::CsrFailsafe:  failsafe_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s1_go, s2_go, accept;

   assign s2_go    = !q_full;
   assign s1_go    = !s2_valid_ff || s2_go;
   assign req_full = s1_valid_ff && !s1_go;
   assign accept   = req_push && !req_full;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);
   assign s2_valid_in = (s1_valid_ff && s1_go) || (s2_valid_ff && !s2_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage 1: clamp (max wins on crossed limits), offset and multiply
   logic [sbfe_pkg::PulseWidth-1:0]         pulse_ff;
   logic [sbfe_pkg::PulseWidth-1:0]         lo_clamped, clamped;
   logic signed [sbfe_pkg::ScaledWidth-1:0] diff;
   logic signed [sbfe_pkg::ScaledWidth-1:0] scaled_in, scaled_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         pulse_ff <= req_pulse_us;
      end
      if (s1_valid_ff && s1_go) begin
         scaled_ff <= scaled_in;
      end
   end

   always_comb begin
      lo_clamped = (pulse_ff < pulse_min_ff) ? pulse_min_ff : pulse_ff;
      clamped    = (lo_clamped > pulse_max_ff) ? pulse_max_ff : lo_clamped;
      diff       = $signed({13'd0, clamped}) - sbfe_pkg::ScaleCenter;
      scaled_in  = diff * sbfe_pkg::ScaleMul + sbfe_pkg::RoundBias;
   end

   // stage 2: divide by 1024 toward zero, offset, clamp, pack
   logic signed [sbfe_pkg::ScaledWidth-1:0] adj;
   logic signed [19:0]                      quot, raw_s;
   logic [sbfe_pkg::RawWidth-1:0]           raw;

   always_comb begin
      adj   = scaled_ff + (scaled_ff[sbfe_pkg::ScaledWidth-1] ? sbfe_pkg::TruncBias
                                                               : '0);
      quot  = 20'(adj >>> sbfe_pkg::ScaleShift);
      raw_s = quot + sbfe_pkg::RawMin;
      if (raw_s < sbfe_pkg::RawMin) begin
         raw_s = sbfe_pkg::RawMin;
      end else if (raw_s > sbfe_pkg::RawMax) begin
         raw_s = sbfe_pkg::RawMax;
      end
      raw = raw_s[sbfe_pkg::RawWidth-1:0];
   end

   logic [sbfe_pkg::ChanWidth-1:0]    chan_ff;
   logic [sbfe_pkg::PendWidth-1:0]    pend_bits_ff, pend_bits_in, start_bits;
   logic [sbfe_pkg::PendCntWidth-1:0] pend_cnt_ff, pend_cnt_in, start_cnt;
   logic [17:0]                       acc;
   logic                              two, first, last;
   logic [sbfe_pkg::ByteWidth-1:0]    flags;

   always_comb begin
      first      = (chan_ff == sbfe_pkg::FirstChannel);
      last       = (chan_ff == sbfe_pkg::LastChannel);
      start_bits = first ? '0 : pend_bits_ff;
      start_cnt  = first ? '0 : pend_cnt_ff;
      acc        = {11'd0, start_bits} | ({7'd0, raw} << start_cnt);
      two        = (start_cnt >= sbfe_pkg::TwoByteCount);
      flags      = (frame_lost_ff ? sbfe_pkg::FlagFrameLost : '0)
                 | (failsafe_ff ? sbfe_pkg::FlagFailsafe : '0);

      push_entry.bytes      = {sbfe_pkg::FooterByte, flags, acc[15:8], acc[7:0]};
      push_entry.count      = two ? 3'd2 : 3'd1;
      push_entry.has_footer = last;
      if (first) begin
         push_entry.bytes[0] = sbfe_pkg::HeaderByte;
         push_entry.bytes[1] = acc[7:0];
         push_entry.count    = 3'd2;
      end
      if (last) begin
         if (!two) begin
            push_entry.bytes[1] = flags;
            push_entry.bytes[2] = sbfe_pkg::FooterByte;
         end
         push_entry.count = push_entry.count + 3'd2;
      end

      pend_bits_in = two ? {5'd0, acc[17:16]} : acc[14:8];
      pend_cnt_in  = two ? start_cnt - sbfe_pkg::TwoByteCount : start_cnt + 3'd3;
      if (last) begin
         pend_bits_in = '0;
         pend_cnt_in  = '0;
      end
   end

   assign push_valid = s2_valid_ff && s2_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= '0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else if (push_valid) begin
         chan_ff      <= chan_ff + 4'd1;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/sbfe_queue.sv -----
// Short entry queue between packer and byte serializer.
`timescale 1ns / 1ps
`default_nettype none
module sbfe_queue #(
   parameter int unsigned Depth = sbfe_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  sbfe_pkg::entry_type       push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output sbfe_pkg::entry_type       head_entry
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   sbfe_pkg::entry_type mem [Depth];

   logic [PtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0] count_ff;
   logic                do_pop;

   assign full       = (count_ff == CntWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push_valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/sbfe_back.sv -----
// Back end: one queue byte per cycle into the result register while it is free.
`timescale 1ns / 1ps
`default_nettype none
module sbfe_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  sbfe_pkg::entry_type                    head_entry,
   output logic                                   pop,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [sbfe_pkg::ByteWidth-1:0]         rsp_out_byte,
   output logic                                   rsp_frame_end
);

   logic                           out_valid_ff;
   logic [sbfe_pkg::ByteWidth-1:0] out_byte_ff;
   logic                           frame_end_ff;
   logic [1:0]                     pos_ff;
   logic                           out_free, load, last_byte;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign load      = out_free && head_valid;
   assign last_byte = ({1'b0, pos_ff} == head_entry.count - 3'd1);
   assign pop       = load && last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (out_free) begin
            out_valid_ff <= head_valid;
         end
         if (load) begin
            pos_ff <= last_byte ? '0 : pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff  <= head_entry.bytes[pos_ff];
         frame_end_ff <= head_entry.has_footer && last_byte;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/sbus_frame_encoder_top.sv -----
// Top level of the 16-channel SBUS frame encoder.
`timescale 1ns / 1ps
`default_nettype none
// Takes one pulse width (us) per transfer, channels 0..15 in order, and returns
// the 25-byte SBUS frame one byte per transfer, frame_end marking the footer.
// A new pulse can be taken every cycle while full is low; the front end
// (clamp/multiply stage, then scale/pack stage) feeds a small entry queue, and
// the back end drains one byte per cycle while the result is being popped.
// Channel 0 yields two bytes (header plus data), channel 15 four (data, data,
// flags, footer), the others one or two, so the sustained rate is set by the
// single byte-per-cycle output register. The user must write registers via the
// csr port (always ready) only while the block is idle; the block does not
// enforce this. Frame flags are taken when channel 15 is packed.
module sbus_frame_encoder_top #(
   parameter int unsigned QueueDepth = sbfe_pkg::QueueDepth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sbfe_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [sbfe_pkg::CsrDataWidth-1:0]   csr_data,
   input  wire logic                                req_push,
   input  wire logic [sbfe_pkg::PulseWidth-1:0]     req_pulse_us,
   output logic                                     full,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [sbfe_pkg::ByteWidth-1:0]           rsp_out_byte,
   output logic                                     rsp_frame_end
);

   logic                push_valid, q_full, head_valid, q_pop;
   sbfe_pkg::entry_type push_entry, head_entry;

   sbfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_push     (req_push),
      .req_pulse_us (req_pulse_us),
      .req_full     (full),
      .push_valid   (push_valid),
      .push_entry   (push_entry),
      .q_full       (q_full)
   );

   sbfe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sbfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (q_pop),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire
